@@ sv/kpp_pkg.sv @@
// Shared types and constants for the key path string parser.
// No dependencies; kpp_step and key_path_string_parser use it by scoped names.

package kpp_pkg;

   localparam logic [7:0] CHAR_SLASH = 8'h2F;
   localparam logic [7:0] CHAR_QUOTE = 8'h27;
   localparam logic [7:0] CHAR_H     = 8'h68;
   localparam logic [7:0] CHAR_M     = 8'h6D;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;

   localparam logic [31:0] HARDENED_KEY_LIMIT = 32'h8000_0000;

   localparam int STATUS_W = 3;
   localparam int VALUE_W  = 32;

   localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd1;
   localparam logic [STATUS_W-1:0] ST_MALFORMED = 3'd2;
   localparam logic [STATUS_W-1:0] ST_INVALID   = 3'd3;
   localparam logic [STATUS_W-1:0] ST_HARDENED  = 3'd4;

   typedef enum logic [4:0] {
      PH_START  = 5'b00001,
      PH_DIGITS = 5'b00010,
      PH_HARD   = 5'b00100,
      PH_MFIRST = 5'b01000,
      PH_MLATE  = 5'b10000
   } phase_type;

   typedef struct packed {
      phase_type           phase;
      logic                first_token;
      logic [VALUE_W-1:0]  number_acc;
      logic                hardened_seen;
      logic                error_swallow;
      logic                string_started;
   } parse_state_type;

   localparam parse_state_type STATE_RESET = '{
      phase:          PH_START,
      first_token:    1'b1,
      number_acc:     '0,
      hardened_seen:  1'b0,
      error_swallow:  1'b0,
      string_started: 1'b0
   };

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic                element_valid;
      logic [VALUE_W-1:0]  element_value;
      logic                path_end;
   } result_type;

endpackage

@@ sv/kpp_step.sv @@
// Combinational next-state and result logic for one path character.
// Depends on kpp_pkg for the state and result types.

module kpp_step (
   input  kpp_pkg::parse_state_type cur_state,
   input  logic [7:0]               char_code,
   input  logic                     has_char,
   input  logic                     last_char,
   output kpp_pkg::parse_state_type nxt_state,
   output logic                     res_emit,
   output kpp_pkg::result_type      res_data
);

   logic        is_digit;
   logic [3:0]  digit_val;
   logic [35:0] acc_times_ten;
   logic        closed;
   logic [31:0] token_value;

   assign is_digit  = (char_code >= kpp_pkg::CHAR_ZERO) && (char_code <= kpp_pkg::CHAR_NINE);
   assign digit_val = is_digit ? 4'(char_code - kpp_pkg::CHAR_ZERO) : 4'd0;
   // Times ten as two shifts and an add, then the new digit.
   assign acc_times_ten = ({4'b0, cur_state.number_acc} << 3)
                        + ({4'b0, cur_state.number_acc} << 1)
                        + {32'b0, digit_val};
   assign token_value = cur_state.number_acc
                      | (cur_state.hardened_seen ? kpp_pkg::HARDENED_KEY_LIMIT : 32'b0);

   always_comb begin
      nxt_state = cur_state;
      res_emit  = 1'b0;
      res_data  = '0;
      closed    = 1'b0;

      if (cur_state.error_swallow) begin
         if (last_char) begin
            nxt_state = kpp_pkg::STATE_RESET;
         end
      end else if (has_char) begin
         nxt_state.string_started = 1'b1;
         case (cur_state.phase)
            kpp_pkg::PH_START: begin
               if (char_code == kpp_pkg::CHAR_SLASH) begin
                  closed          = 1'b1;
                  res_data.status = kpp_pkg::ST_MALFORMED;
               end else if (is_digit) begin
                  nxt_state.number_acc = {28'b0, digit_val};
                  nxt_state.phase      = kpp_pkg::PH_DIGITS;
               end else if (char_code == kpp_pkg::CHAR_M) begin
                  nxt_state.phase = cur_state.first_token ? kpp_pkg::PH_MFIRST
                                                          : kpp_pkg::PH_MLATE;
               end else begin
                  closed          = 1'b1;
                  res_data.status = kpp_pkg::ST_INVALID;
               end
            end
            kpp_pkg::PH_DIGITS: begin
               if (is_digit) begin
                  if (acc_times_ten[35:32] != 4'b0) begin
                     closed          = 1'b1;
                     res_data.status = kpp_pkg::ST_INVALID;
                  end else begin
                     nxt_state.number_acc = acc_times_ten[31:0];
                  end
               end else if (char_code == kpp_pkg::CHAR_SLASH) begin
                  closed = 1'b1;
               end else if (char_code == kpp_pkg::CHAR_QUOTE || char_code == kpp_pkg::CHAR_H) begin
                  if (cur_state.number_acc[31]) begin
                     closed          = 1'b1;
                     res_data.status = kpp_pkg::ST_HARDENED;
                  end else begin
                     nxt_state.hardened_seen = 1'b1;
                     nxt_state.phase         = kpp_pkg::PH_HARD;
                  end
               end else begin
                  closed          = 1'b1;
                  res_data.status = kpp_pkg::ST_INVALID;
               end
            end
            kpp_pkg::PH_HARD: begin
               closed = 1'b1;
               if (char_code != kpp_pkg::CHAR_SLASH) begin
                  res_data.status = kpp_pkg::ST_MALFORMED;
               end
            end
            kpp_pkg::PH_MFIRST: begin
               if (char_code != kpp_pkg::CHAR_SLASH) begin
                  closed          = 1'b1;
                  res_data.status = kpp_pkg::ST_INVALID;
               end else if (last_char) begin
                  closed          = 1'b1;
                  res_data.status = kpp_pkg::ST_MALFORMED;
               end else begin
                  nxt_state.first_token = 1'b0;
                  nxt_state.phase       = kpp_pkg::PH_START;
                  closed                = 1'b1;
               end
            end
            default: begin
               closed          = 1'b1;
               res_data.status = (char_code == kpp_pkg::CHAR_SLASH) ? kpp_pkg::ST_MALFORMED
                                                                    : kpp_pkg::ST_INVALID;
            end
         endcase

         // A slash that closes a number token emits the element, unless the
         // string ends on it, which is an empty-token error instead.
         if (closed && res_data.status == kpp_pkg::ST_OK
             && cur_state.phase != kpp_pkg::PH_MFIRST) begin
            if (last_char) begin
               res_data.status = kpp_pkg::ST_MALFORMED;
            end else begin
               nxt_state.phase         = kpp_pkg::PH_START;
               nxt_state.number_acc    = '0;
               nxt_state.hardened_seen = 1'b0;
               nxt_state.first_token   = 1'b0;
               res_emit                = 1'b1;
               res_data.element_valid  = 1'b1;
               res_data.element_value  = token_value;
            end
         end

         if (res_data.status != kpp_pkg::ST_OK) begin
            res_emit          = 1'b1;
            res_data.path_end = 1'b1;
            if (last_char) begin
               nxt_state = kpp_pkg::STATE_RESET;
            end else begin
               nxt_state.error_swallow = 1'b1;
            end
         end
      end

      // End of string after the character, or a bare end item, in the
      // phase that is now current.
      if (!cur_state.error_swallow && last_char && !closed) begin
         res_emit          = 1'b1;
         res_data          = '0;
         res_data.path_end = 1'b1;
         case (nxt_state.phase)
            kpp_pkg::PH_DIGITS, kpp_pkg::PH_HARD: begin
               res_data.element_valid = 1'b1;
               res_data.element_value = nxt_state.number_acc
                  | (nxt_state.hardened_seen ? kpp_pkg::HARDENED_KEY_LIMIT : 32'b0);
            end
            kpp_pkg::PH_MFIRST: begin
               res_data.status = kpp_pkg::ST_OK;
            end
            kpp_pkg::PH_MLATE: begin
               res_data.status = kpp_pkg::ST_MALFORMED;
            end
            default: begin
               res_data.status = nxt_state.string_started ? kpp_pkg::ST_MALFORMED
                                                          : kpp_pkg::ST_EMPTY;
            end
         endcase
         nxt_state = kpp_pkg::STATE_RESET;
      end
   end

endmodule

@@ sv/key_path_string_parser.sv @@
// Top level of the key path string parser: state register, output stage.
// Depends on kpp_pkg and kpp_step.

// The path text arrives one byte per req transfer: tdata carries the
// character, tuser is set when the byte is present, and tlast marks the
// final item of a string (a transfer with tuser low and tlast high is a bare
// end of string). Each closed path element, the final outcome of a string,
// or the first error is sent as one rsp transfer; status sits in the low
// tdata bits, tuser flags a valid element and tlast marks the end of a path.
// After an error, items up to and including the next tlast give nothing.
// One character is taken every cycle while the skid register is empty; the
// character update is a single registered pass (times-ten accumulate,
// overflow check, phase decode), and each result is registered before rsp.
// Reset clears the parse state and empties the output stage; no clearing
// pass is needed. When the receiver stalls, one result is held in the output
// register and one more in a skid register; req_tready drops only while the
// skid register is full.

module key_path_string_parser (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,  // [7:0] char_code
   input  logic        req_tuser,  // [0] has_char
   input  logic        req_tlast,  // last_char
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,  // [2:0] status, [34:3] element_value, rest zero
   output logic        rsp_tuser,  // [0] element_valid
   output logic        rsp_tlast   // path_end
);

   kpp_pkg::parse_state_type state_ff, state_in;
   kpp_pkg::result_type      step_res;
   logic                     step_emit;

   logic                     out_valid_ff, out_valid_in;
   kpp_pkg::result_type      out_data_ff, out_data_in;
   logic                     skid_valid_ff, skid_valid_in;
   kpp_pkg::result_type      skid_data_ff, skid_data_in;

   logic                     req_fire;
   logic                     new_res;
   logic                     main_free;

   kpp_step u_step (
      .cur_state (state_ff),
      .char_code (req_tdata),
      .has_char  (req_tuser),
      .last_char (req_tlast),
      .nxt_state (state_in),
      .res_emit  (step_emit),
      .res_data  (step_res)
   );

   assign req_tready = !skid_valid_ff;
   assign req_fire   = req_tvalid && req_tready;
   assign new_res    = req_fire && step_emit;
   assign main_free  = !out_valid_ff || rsp_tready;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (main_free) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = new_res;
            out_data_in  = step_res;
         end
      end else if (new_res) begin
         skid_valid_in = 1'b1;
         skid_data_in  = step_res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= kpp_pkg::STATE_RESET;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (req_fire) begin
            state_ff <= state_in;
         end
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {5'b0, out_data_ff.element_value, out_data_ff.status};
   assign rsp_tuser  = out_data_ff.element_valid;
   assign rsp_tlast  = out_data_ff.path_end;

   // The skid register only fills behind a held output register.
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid register full while output register empty");

   // Error results always end the path and carry no element.
   a_error_ends_path: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && out_data_ff.status != kpp_pkg::ST_OK)
         |-> (rsp_tlast && !rsp_tuser && out_data_ff.element_value == '0))
      else $error("error result without path end or with an element");

   // A path end returns the parser to its idle state, or to error swallowing.
   a_end_resets_state: assert property (@(posedge clock) disable iff (reset)
      (req_fire && step_emit && step_res.path_end) |=>
         (state_ff == kpp_pkg::STATE_RESET || state_ff.error_swallow))
      else $error("parse state not cleared after the end of a path");

endmodule
